FILE: src/pfr_pkg.sv
// Package with types, constants and state codes for the page frame replacement unit.
package pfr_pkg;

    localparam int FRAMES_DEF = 16;
    localparam int VPAGES_DEF = 256;
    localparam int PARTS_DEF = 4;
    localparam int FLUSH_PERIOD_DEF = 1000;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_CLOCK = 2'd1;
    localparam logic [1:0] POL_LRU   = 2'd2;
    localparam logic [1:0] POL_NRU   = 2'd3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_LOCAL = 2'd1;
    localparam logic [1:0] REG_PSIZE = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] virtual_page;
        logic [7:0] word_offset;
        logic [1:0] partition;
    } pfr_in_t;

    typedef struct packed {
        logic        hit;
        logic        loaded;
        logic [3:0]  frame;
        logic [7:0]  evicted_page;
        logic [11:0] physical_address;
    } pfr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLOCK,
        ST_SCAN,
        ST_LOAD,
        ST_FLUSH,
        ST_DONE
    } pfr_state_t;

endpackage

FILE: src/page_frame_replacement.sv
// Top level of the page frame replacement unit: lookup, victim selection and load.
//
// Usage: drive an access on cmd and pulse start while busy is low; the transfer
// is taken at that edge and busy rises. The unit looks the page up one frame per
// cycle, and on a read miss picks a victim with a single compare unit that steps
// over the frames under a small sequencer. When done, res carries the result for
// exactly one cycle, marked by res_valid; the receiver cannot stall it.
// A hit ends the lookup at the matching frame; a miss looks at every frame. A
// write miss then gives its result; a read miss picks a victim and loads it:
// FIFO takes its pointer with no search, LRU scans the range for a frame not
// recently used, clock steps from its pointer clearing set reference bits and
// NRU makes up to four passes, one per class. The LRU flush is part of the load.
// A new transfer can be accepted in the result cycle; one item is in work at a time.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, which the user
// must write only while idle, unenforced by the unit; cfg_ready is always high.
// Reset: rst_n clears the frame table to page i in frame i, all flags to zero,
// all pointers to their quarter start, the LRU count to zero and the registers
// to FIFO, global mode and page size 16 words.
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    parameter int PARTS = PARTS_DEF,
    parameter int FLUSH_PERIOD = FLUSH_PERIOD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  pfr_in_t    cmd,
    output logic       res_valid,
    output pfr_out_t   res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int QLEN = FRAMES / PARTS;
    localparam int CW = (FLUSH_PERIOD > 1) ? $clog2(FLUSH_PERIOD + 1) : 1;
    localparam int SW = FW + 2;

    pfr_state_t state_reg, state_next;
    logic [1:0] policy_reg;
    logic local_reg;
    logic [3:0] psize_reg;
    pfr_in_t cmd_reg;
    logic [7:0] page_reg [FRAMES];
    logic [FRAMES-1:0] ref_reg, mod_reg, rec_reg;
    logic [FW-1:0] fifo_ptr_reg [PARTS];
    logic [FW-1:0] clk_ptr_reg [PARTS];
    logic [CW-1:0] lru_cnt_reg;
    logic [FW-1:0] idx_reg, idx_next;
    logic [SW-1:0] step_reg, step_next;
    logic [1:0] cls_reg, cls_next;
    logic hit_reg, hit_next;
    logic [FW-1:0] vic_reg, vic_next;
    logic flush_reg, flush_next;
    pfr_out_t res_reg;
    logic res_valid_reg;

    logic [FW-1:0] rstart, rlen_m1, rend;
    logic [1:0] slot;
    logic [FW-1:0] cur_ptr;
    logic [FW-1:0] ptr_fixed;
    logic [FW-1:0] idx_wrap;
    logic [3:0] psl;

    assign cfg_ready = 1'b1;
    assign busy = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    always_comb
    begin
        if (local_reg)
        begin
            slot = cmd_reg.partition;
            rstart = FW'(32'(cmd_reg.partition) * QLEN);
            rlen_m1 = FW'(QLEN - 1);
        end
        else
        begin
            slot = 2'd0;
            rstart = '0;
            rlen_m1 = FW'(FRAMES - 1);
        end
        rend = rstart + rlen_m1;
        cur_ptr = (policy_reg == POL_FIFO) ? fifo_ptr_reg[slot] : clk_ptr_reg[slot];
        ptr_fixed = (cur_ptr < rstart || cur_ptr > rend) ? rstart : cur_ptr;
        idx_wrap = (idx_reg == rend) ? rstart : idx_reg + FW'(1);
        psl = (psize_reg > 4'd8) ? 4'd8 : psize_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        step_next = step_reg;
        cls_next = cls_reg;
        hit_next = hit_reg;
        vic_next = vic_reg;
        flush_next = flush_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                    idx_next = '0;
                    hit_next = 1'b0;
                end
            end
            ST_LOOKUP:
            begin
                if (page_reg[idx_reg] == cmd_reg.virtual_page)
                begin
                    hit_next = 1'b1;
                    vic_next = idx_reg;
                    state_next = ST_DONE;
                end
                else if (32'(idx_reg) == FRAMES - 1)
                begin
                    if (cmd_reg.func)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = rstart;
                        step_next = '0;
                        cls_next = 2'd0;
                        vic_next = rstart;
                        case (policy_reg)
                            POL_FIFO:
                            begin
                                vic_next = ptr_fixed;
                                state_next = ST_LOAD;
                            end
                            POL_CLOCK:
                            begin
                                idx_next = ptr_fixed;
                                state_next = ST_CLOCK;
                            end
                            default:
                            begin
                                state_next = ST_SCAN;
                            end
                        endcase
                    end
                end
                else
                begin
                    idx_next = idx_reg + FW'(1);
                end
            end
            ST_CLOCK:
            begin
                if (ref_reg[idx_reg] && SW'(step_reg) <= SW'(rlen_m1) + SW'(1))
                begin
                    idx_next = idx_wrap;
                    step_next = step_reg + SW'(1);
                end
                else
                begin
                    vic_next = idx_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_SCAN:
            begin
                if (policy_reg == POL_LRU)
                begin
                    if (!rec_reg[idx_reg])
                    begin
                        vic_next = idx_reg;
                        state_next = ST_LOAD;
                    end
                    else if (idx_reg == rend)
                    begin
                        vic_next = rstart;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + FW'(1);
                    end
                end
                else
                begin
                    if (ref_reg[idx_reg] == cls_reg[1] && mod_reg[idx_reg] == cls_reg[0])
                    begin
                        vic_next = idx_reg;
                        state_next = ST_LOAD;
                    end
                    else if (idx_reg == rend)
                    begin
                        idx_next = rstart;
                        cls_next = cls_reg + 2'd1;
                        if (cls_reg == 2'd3)
                        begin
                            vic_next = rstart;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + FW'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                flush_next = 1'b0;
                state_next = ST_DONE;
                if (policy_reg == POL_LRU && 32'(lru_cnt_reg) + 1 >= FLUSH_PERIOD)
                begin
                    flush_next = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            policy_reg <= POL_FIFO;
            local_reg <= 1'b0;
            psize_reg <= 4'd4;
            cmd_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                page_reg[i] <= 8'(i);
            end
            ref_reg <= '0;
            mod_reg <= '0;
            rec_reg <= '0;
            for (int q = 0; q < PARTS; q++)
            begin
                fifo_ptr_reg[q] <= FW'(q * QLEN);
                clk_ptr_reg[q] <= FW'(q * QLEN);
            end
            lru_cnt_reg <= '0;
            idx_reg <= '0;
            step_reg <= '0;
            cls_reg <= '0;
            hit_reg <= 1'b0;
            vic_reg <= '0;
            flush_reg <= 1'b0;
            res_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            step_reg <= step_next;
            cls_reg <= cls_next;
            hit_reg <= hit_next;
            vic_reg <= vic_next;
            flush_reg <= flush_next;
            res_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POLICY: policy_reg <= cfg_data[1:0];
                    REG_LOCAL: local_reg <= cfg_data[0];
                    REG_PSIZE: psize_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE && start)
            begin
                cmd_reg <= cmd;
            end
            if (state_reg == ST_CLOCK && state_next == ST_CLOCK)
            begin
                ref_reg[idx_reg] <= 1'b0;
            end
            if (state_reg == ST_LOAD)
            begin
                page_reg[vic_reg] <= cmd_reg.virtual_page;
                ref_reg[vic_reg] <= 1'b1;
                mod_reg[vic_reg] <= 1'b0;
                if (flush_next)
                begin
                    rec_reg <= FRAMES'(1) << vic_reg;
                    lru_cnt_reg <= '0;
                end
                else
                begin
                    rec_reg[vic_reg] <= 1'b1;
                    if (policy_reg == POL_LRU)
                    begin
                        lru_cnt_reg <= lru_cnt_reg + CW'(1);
                    end
                end
                if (policy_reg == POL_FIFO)
                begin
                    fifo_ptr_reg[slot] <= (vic_reg == rend) ? rstart : vic_reg + FW'(1);
                end
                if (policy_reg == POL_CLOCK)
                begin
                    clk_ptr_reg[slot] <= (vic_reg == rend) ? rstart : vic_reg + FW'(1);
                end
                res_reg.evicted_page <= page_reg[vic_reg];
            end
            if (state_reg == ST_DONE)
            begin
                res_valid_reg <= 1'b1;
                res_reg.hit <= hit_reg;
                res_reg.loaded <= !hit_reg && !cmd_reg.func;
                if (hit_reg)
                begin
                    mod_reg[vic_reg] <= 1'b1;
                    res_reg.evicted_page <= '0;
                end
                if (hit_reg || !cmd_reg.func)
                begin
                    res_reg.frame <= 4'(vic_reg);
                    res_reg.physical_address <= 12'((20'(vic_reg) << psl)
                        + (20'(cmd_reg.word_offset) & ((20'd1 << psl) - 20'd1)));
                end
                else
                begin
                    res_reg.frame <= '0;
                    res_reg.evicted_page <= '0;
                    res_reg.physical_address <= '0;
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res.hit && res.loaded))
        else $error("hit and loaded both set");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !res_valid)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> busy)
        else $error("transfer accepted without busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (vic_reg >= rstart && vic_reg <= rend))
        else $error("victim outside its range");

endmodule
